[rtl/core/threshold_alarm_qualifier_macros.svh]
// assertion macros shared by the alarm qualifier rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef THRESHOLD_ALARM_QUALIFIER_MACROS_SVH
`define THRESHOLD_ALARM_QUALIFIER_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every rising clock edge out of reset
`define TAQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("taq assertion failed");

// condition must never be true out of reset
`define TAQ_ASSERT_NEVER(label, cond) \
  `TAQ_ASSERT(label, !(cond))

`else

`define TAQ_ASSERT(label, prop)
`define TAQ_ASSERT_NEVER(label, cond)

`endif

`endif

[rtl/core/taq_pkg.sv]
// types, codes and widths for the threshold alarm qualifier
// no dependencies
`default_nettype none

package taq_pkg;

  localparam int unsigned CntW  = 17;
  localparam int unsigned DataW = 32;
  localparam int unsigned SecW  = 24;
  localparam int unsigned IdxW  = 3;

  typedef enum logic [1:0] {
    MODE_HIGH = 2'd0,
    MODE_LOW  = 2'd1,
    MODE_NONE = 2'd2,
    MODE_OFF  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CLASS_NORMAL  = 2'd0,
    CLASS_WARNING = 2'd1,
    CLASS_ALARM   = 2'd2,
    CLASS_NONE    = 2'd3
  } class_e;

  typedef enum logic [1:0] {
    PHASE_CHECK   = 2'd0,
    PHASE_ALARM   = 2'd1,
    PHASE_DORMANT = 2'd2,
    PHASE_UNUSED  = 2'd3
  } phase_e;

  typedef enum logic [IdxW-1:0] {
    REG_COMPARE_MODE    = 3'd0,
    REG_WARNING_LEVEL   = 3'd1,
    REG_ALARM_LEVEL     = 3'd2,
    REG_CHECK_WINDOW    = 3'd3,
    REG_HIT_FRACTION    = 3'd4,
    REG_HOLD_SECONDS    = 3'd5,
    REG_DORMANT_SECONDS = 3'd6,
    REG_SPARE           = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [1:0]       compare_mode;
    logic [DataW-1:0] warning_level;
    logic [DataW-1:0] alarm_level;
    logic [15:0]      check_window;
    logic [CntW-1:0]  hit_fraction;
    logic [SecW-1:0]  hold_seconds;
    logic [SecW-1:0]  dormant_seconds;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       sample_class;
    logic [1:0]       phase;
    logic             alarm_raised;
    logic             warning_raised;
    logic             alarm_ended;
    logic             dormancy_ended;
    logic [DataW-1:0] seconds_left;
  } result_t;

endpackage

`default_nettype wire

[rtl/core/taq_cfg_regs.sv]
// configuration register file of the alarm qualifier
// depends on taq_pkg
`default_nettype none

module taq_cfg_regs
  import taq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IdxW-1:0]   cfg_index_i,
  input  wire logic [DataW-1:0]  cfg_wdata_i,
  output cfg_t                   cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.compare_mode    <= MODE_HIGH;
      cfg_q.warning_level   <= '0;
      cfg_q.alarm_level     <= '0;
      cfg_q.check_window    <= 16'd10;
      cfg_q.hit_fraction    <= 17'd32768;
      cfg_q.hold_seconds    <= 24'd60;
      cfg_q.dormant_seconds <= 24'd60;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_COMPARE_MODE:    cfg_q.compare_mode    <= cfg_wdata_i[1:0];
        REG_WARNING_LEVEL:   cfg_q.warning_level   <= cfg_wdata_i;
        REG_ALARM_LEVEL:     cfg_q.alarm_level     <= cfg_wdata_i;
        REG_CHECK_WINDOW:    cfg_q.check_window    <= cfg_wdata_i[15:0];
        REG_HIT_FRACTION:    cfg_q.hit_fraction    <= cfg_wdata_i[CntW-1:0];
        REG_HOLD_SECONDS:    cfg_q.hold_seconds    <= cfg_wdata_i[SecW-1:0];
        REG_DORMANT_SECONDS: cfg_q.dormant_seconds <= cfg_wdata_i[SecW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[rtl/core/taq_step_core.sv]
// qualifier state and the per-sample update logic
// depends on taq_pkg and threshold_alarm_qualifier_macros.svh
`default_nettype none
`include "threshold_alarm_qualifier_macros.svh"

module taq_step_core
  import taq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_en_i,
  input  wire logic [DataW-1:0]  sample_value_i,
  input  wire logic [DataW-1:0]  now_seconds_i,
  input  cfg_t                   cfg_i,
  output result_t                res_o
);

  logic [CntW-1:0]  window_count_q, window_count_d;
  logic [CntW-1:0]  warning_hits_q, warning_hits_d;
  logic [CntW-1:0]  alarm_hits_q, alarm_hits_d;
  logic             first_hit_pending_q, first_hit_pending_d;
  logic             alarm_on_q, alarm_on_d;
  logic             dormant_on_q, dormant_on_d;
  logic [DataW-1:0] phase_start_q, phase_start_d;

  logic             in_window, classify_en, hi_mode, a_hit, w_hit;
  logic [CntW-1:0]  wc_base, wc_new, ah_new, wh_new;
  logic             eval_now;
  logic [33:0]      thr_prod, alarm_scaled, warning_scaled;
  logic [DataW-1:0] hold_left, dorm_left, dorm_elapsed;
  logic             hold_expired, dorm_expired;

  // window step and classification
  assign in_window   = window_count_q <= {1'b0, cfg_i.check_window};
  assign classify_en = in_window &&
                       (cfg_i.compare_mode == MODE_HIGH || cfg_i.compare_mode == MODE_LOW);
  assign hi_mode = cfg_i.compare_mode == MODE_HIGH;
  assign a_hit = hi_mode ? ($signed(sample_value_i) > $signed(cfg_i.alarm_level))
                         : ($signed(sample_value_i) < $signed(cfg_i.alarm_level));
  assign w_hit = hi_mode ? ($signed(sample_value_i) > $signed(cfg_i.warning_level))
                         : ($signed(sample_value_i) < $signed(cfg_i.warning_level));

  // first alarm hit of a window restarts the count
  assign wc_base = (classify_en && a_hit && first_hit_pending_q) ? '0 : window_count_q;
  assign wc_new  = in_window ? wc_base + 1'b1 : window_count_q;
  assign ah_new  = (classify_en && a_hit) ? alarm_hits_q + 1'b1 : alarm_hits_q;
  assign wh_new  = (classify_en && !a_hit && w_hit) ? warning_hits_q + 1'b1 : warning_hits_q;
  assign eval_now = wc_new > {1'b0, cfg_i.check_window};

  // hits / count > fraction / 2^16, cross multiplied
  assign thr_prod       = 34'(cfg_i.hit_fraction) * 34'(wc_new);
  assign alarm_scaled   = {1'b0, ah_new, 16'b0};
  assign warning_scaled = {1'b0, wh_new, 16'b0};

  // hold and dormancy timers, dormancy starts now when the hold expires
  assign hold_left    = 32'(cfg_i.hold_seconds) - (now_seconds_i - phase_start_q);
  assign hold_expired = alarm_on_q && (hold_left[DataW-1] || hold_left == '0);
  assign dorm_elapsed = hold_expired ? '0 : (now_seconds_i - phase_start_q);
  assign dorm_left    = 32'(cfg_i.dormant_seconds) - dorm_elapsed;
  assign dorm_expired = dorm_left[DataW-1] || dorm_left == '0;

  always_comb begin
    window_count_d      = window_count_q;
    warning_hits_d      = warning_hits_q;
    alarm_hits_d        = alarm_hits_q;
    first_hit_pending_d = first_hit_pending_q;
    alarm_on_d          = alarm_on_q;
    dormant_on_d        = dormant_on_q;
    phase_start_d       = phase_start_q;
    res_o               = '0;
    res_o.sample_class  = CLASS_NONE;

    if (!alarm_on_q && !dormant_on_q) begin
      if (classify_en) begin
        res_o.sample_class = a_hit ? CLASS_ALARM : (w_hit ? CLASS_WARNING : CLASS_NORMAL);
      end
      window_count_d = wc_new;
      alarm_hits_d   = ah_new;
      warning_hits_d = wh_new;
      if (classify_en && a_hit) begin
        first_hit_pending_d = 1'b0;
      end
      if (eval_now) begin
        if (alarm_scaled > thr_prod) begin
          alarm_on_d         = 1'b1;
          phase_start_d      = now_seconds_i;
          res_o.alarm_raised = 1'b1;
        end else if (warning_scaled > thr_prod) begin
          res_o.warning_raised = 1'b1;
        end
        window_count_d      = '0;
        first_hit_pending_d = 1'b1;
        warning_hits_d      = '0;
        alarm_hits_d        = '0;
      end
    end else if (alarm_on_q && !hold_expired) begin
      res_o.seconds_left = hold_left;
    end else begin
      // dormant, possibly entered in this very step
      if (hold_expired) begin
        phase_start_d       = now_seconds_i;
        alarm_on_d          = 1'b0;
        first_hit_pending_d = 1'b1;
        res_o.alarm_ended   = 1'b1;
      end
      dormant_on_d       = !dorm_expired;
      res_o.dormancy_ended = dorm_expired;
      res_o.seconds_left = dorm_left;
    end

    res_o.phase = alarm_on_d ? PHASE_ALARM : (dormant_on_d ? PHASE_DORMANT : PHASE_CHECK);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_count_q      <= '0;
      warning_hits_q      <= '0;
      alarm_hits_q        <= '0;
      first_hit_pending_q <= 1'b1;
      alarm_on_q          <= 1'b0;
      dormant_on_q        <= 1'b0;
      phase_start_q       <= '0;
    end else if (step_en_i) begin
      window_count_q      <= window_count_d;
      warning_hits_q      <= warning_hits_d;
      alarm_hits_q        <= alarm_hits_d;
      first_hit_pending_q <= first_hit_pending_d;
      alarm_on_q          <= alarm_on_d;
      dormant_on_q        <= dormant_on_d;
      phase_start_q       <= phase_start_d;
    end
  end

  `TAQ_ASSERT_NEVER(a_alarm_and_dormant, alarm_on_q && dormant_on_q)
  `TAQ_ASSERT(a_alarm_needs_step, $rose(alarm_on_q) |-> $past(step_en_i))
  `TAQ_ASSERT(a_counts_hold_when_idle, !step_en_i |=> $stable(window_count_q))

endmodule

`default_nettype wire

[rtl/core/threshold_alarm_qualifier.sv]
// top level of the single channel threshold alarm qualifier
// depends on taq_pkg, taq_cfg_regs, taq_step_core and the assertion macros
//
// usage:
//  - sample requests come in on in_valid_i / in_ready_o with sample_value_i
//    (signed q15.16) and now_seconds_i; results leave on out_valid_o /
//    out_ready_i, exactly one result per sample, in order
//  - configuration is written through cfg_we_i / cfg_index_i / cfg_wdata_i,
//    one register per cycle, only while no sample is in flight
//  - the accepting edge loads the input register, the update logic runs
//    between it and the result register, and out_valid_o rises once the
//    request moves on into the result register, when the output is free
//  - one sample per cycle while the receiver is ready; the longest path is
//    the 17x17 cross-multiplied fraction compare feeding the state registers
//  - when the receiver stalls the result register holds, the input register
//    takes one more request, then in_ready_o drops until the result is taken
//  - reset clears both pipeline stages, loads the register defaults and puts
//    the qualifier in the checking phase with empty counts
`default_nettype none
`include "threshold_alarm_qualifier_macros.svh"

module threshold_alarm_qualifier
  import taq_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [IdxW-1:0]   cfg_index_i,
  input  wire logic [DataW-1:0]  cfg_wdata_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [DataW-1:0]  sample_value_i,
  input  wire logic [DataW-1:0]  now_seconds_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             sample_class_o,
  output logic [1:0]             phase_o,
  output logic                   alarm_raised_o,
  output logic                   warning_raised_o,
  output logic                   alarm_ended_o,
  output logic                   dormancy_ended_o,
  output logic [DataW-1:0]       seconds_left_o
);

  cfg_t             cfg;
  result_t          res_d, res_q;
  logic             in_valid_q, out_valid_q;
  logic [DataW-1:0] sample_q, now_q;
  logic             advance;

  // input register moves into the result register when that one is free
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  taq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  // state only advances when the request actually moves on
  taq_step_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_en_i      (advance),
    .sample_value_i (sample_q),
    .now_seconds_i  (now_q),
    .cfg_i          (cfg),
    .res_o          (res_d)
  );

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sample_q <= sample_value_i;
      now_q    <= now_seconds_i;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= advance;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign sample_class_o   = res_q.sample_class;
  assign phase_o          = res_q.phase;
  assign alarm_raised_o   = res_q.alarm_raised;
  assign warning_raised_o = res_q.warning_raised;
  assign alarm_ended_o    = res_q.alarm_ended;
  assign dormancy_ended_o = res_q.dormancy_ended;
  assign seconds_left_o   = res_q.seconds_left;

  `TAQ_ASSERT_NEVER(a_raise_both, out_valid_o && alarm_raised_o && warning_raised_o)
  `TAQ_ASSERT(a_raise_phase, out_valid_o && alarm_raised_o |-> phase_o == PHASE_ALARM)
  `TAQ_ASSERT(a_end_phase,
    out_valid_o && alarm_ended_o |-> phase_o == PHASE_DORMANT || dormancy_ended_o)

endmodule

`default_nettype wire

[tb/threshold_alarm_qualifier_tb.sv]
// self-checking testbench for the threshold alarm qualifier
// predicts each result from a local copy of the qualifier state and checks it
// depends on taq_pkg and threshold_alarm_qualifier
`timescale 1ns / 1ps

module threshold_alarm_qualifier_tb;
  import taq_pkg::*;

  // dut ports, every input known from time zero
  logic             clk_i          = 1'b0;
  logic             rst_ni         = 1'b0;
  logic             cfg_we_i       = 1'b0;
  logic [IdxW-1:0]  cfg_index_i    = '0;
  logic [DataW-1:0] cfg_wdata_i    = '0;
  logic             in_valid_i     = 1'b0;
  logic             in_ready_o;
  logic [DataW-1:0] sample_value_i = '0;
  logic [DataW-1:0] now_seconds_i  = '0;
  logic             out_valid_o;
  logic             out_ready_i    = 1'b0;
  logic [1:0]       sample_class_o;
  logic [1:0]       phase_o;
  logic             alarm_raised_o;
  logic             warning_raised_o;
  logic             alarm_ended_o;
  logic             dormancy_ended_o;
  logic [DataW-1:0] seconds_left_o;

  // shadow copy of the register file, updated on every write
  cfg_t shadow_cfg;

  // qualifier state as the block should hold it
  logic [CntW-1:0]  win_cnt;
  logic [CntW-1:0]  warn_hits;
  logic [CntW-1:0]  alarm_hits;
  logic             first_pending;
  logic             alarm_held;
  logic             dormant;
  logic [DataW-1:0] phase_t0;

  // results predicted for accepted requests, oldest first
  result_t pending_results[$];

  // traffic shaping, percentages per cycle
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned rx_holdoff     = 0;  // cycles the receiver refuses outright
  int unsigned hot_pct        = 0;  // share of samples pushed past the alarm level
  logic [DataW-1:0] clock_seconds = '0;

  // bookkeeping for the final verdict and the summary
  int unsigned mismatch_count = 0;
  int unsigned n_sent         = 0;
  int unsigned n_checked      = 0;
  int unsigned n_alarms       = 0;
  int unsigned n_warnings     = 0;
  int unsigned n_holds_ended  = 0;
  int unsigned n_dormant_end  = 0;

  threshold_alarm_qualifier uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .sample_value_i   (sample_value_i),
    .now_seconds_i    (now_seconds_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .sample_class_o   (sample_class_o),
    .phase_o          (phase_o),
    .alarm_raised_o   (alarm_raised_o),
    .warning_raised_o (warning_raised_o),
    .alarm_ended_o    (alarm_ended_o),
    .dormancy_ended_o (dormancy_ended_o),
    .seconds_left_o   (seconds_left_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // hits / count > hit_fraction / 65536, cross-multiplied so nothing rounds
  function automatic bit fraction_above(input logic [CntW-1:0] hits,
                                        input logic [CntW-1:0] count);
    logic [63:0] scaled_hits;
    logic [63:0] scaled_limit;
    scaled_hits  = {31'b0, hits, 16'b0};
    scaled_limit = 64'(shadow_cfg.hit_fraction) * 64'(count);
    return scaled_hits > scaled_limit;
  endfunction

  // one qualifier step: classify, count, evaluate the window, run the timers
  function automatic result_t advance_qualifier(input logic signed [DataW-1:0] value,
                                                input logic [DataW-1:0] now);
    result_t r;
    logic alarm_hit;
    logic warn_hit;
    logic [DataW-1:0] left;
    r = '0;
    r.sample_class = CLASS_NONE;
    left = '0;
    if (!alarm_held && !dormant) begin
      // a window lowered below the running count skips classification
      if (win_cnt <= shadow_cfg.check_window) begin
        if (shadow_cfg.compare_mode == MODE_HIGH || shadow_cfg.compare_mode == MODE_LOW) begin
          if (shadow_cfg.compare_mode == MODE_HIGH) begin
            alarm_hit = value > $signed(shadow_cfg.alarm_level);
            warn_hit  = value > $signed(shadow_cfg.warning_level);
          end else begin
            alarm_hit = value < $signed(shadow_cfg.alarm_level);
            warn_hit  = value < $signed(shadow_cfg.warning_level);
          end
          if (alarm_hit) begin
            // first alarm-level hit restarts the window count
            if (first_pending) begin
              first_pending = 1'b0;
              win_cnt = '0;
            end
            alarm_hits = alarm_hits + 1'b1;
            r.sample_class = CLASS_ALARM;
          end else if (warn_hit) begin
            warn_hits = warn_hits + 1'b1;
            r.sample_class = CLASS_WARNING;
          end else begin
            r.sample_class = CLASS_NORMAL;
          end
        end
        // the count advances even when nothing is classified
        win_cnt = win_cnt + 1'b1;
      end
      if (win_cnt > shadow_cfg.check_window) begin
        if (fraction_above(alarm_hits, win_cnt)) begin
          alarm_held = 1'b1;
          phase_t0 = now;
          r.alarm_raised = 1'b1;
        end else if (fraction_above(warn_hits, win_cnt)) begin
          r.warning_raised = 1'b1;
        end
        win_cnt = '0;
        first_pending = 1'b1;
        warn_hits = '0;
        alarm_hits = '0;
      end
    end else begin
      // samples are ignored while held or dormant; time differences wrap at 32 bits
      if (alarm_held) begin
        left = {8'b0, shadow_cfg.hold_seconds} - (now - phase_t0);
        if ($signed(left) <= 0) begin
          phase_t0 = now;
          alarm_held = 1'b0;
          first_pending = 1'b1;
          dormant = 1'b1;
          r.alarm_ended = 1'b1;
        end
      end
      // dormancy is checked in the same step the hold runs out
      if (dormant && !alarm_held) begin
        left = {8'b0, shadow_cfg.dormant_seconds} - (now - phase_t0);
        if ($signed(left) <= 0) begin
          dormant = 1'b0;
          r.dormancy_ended = 1'b1;
        end
      end
    end
    r.seconds_left = left;
    r.phase = alarm_held ? PHASE_ALARM : (dormant ? PHASE_DORMANT : PHASE_CHECK);
    return r;
  endfunction

  // offer one request, wait for the handshake, then record what should come out
  task automatic send_sample(input logic [DataW-1:0] value, input logic [DataW-1:0] now);
    result_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    sample_value_i <= value;
    now_seconds_i  <= now;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = advance_qualifier(value, now);
    pending_results.insert(pending_results.size(), predicted);
    n_sent++;
    n_alarms      += predicted.alarm_raised;
    n_warnings    += predicted.warning_raised;
    n_holds_ended += predicted.alarm_ended;
    n_dormant_end += predicted.dormancy_ended;
  endtask

  // stop offering and wait until every predicted result has been taken
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_COMPARE_MODE:    shadow_cfg.compare_mode    = data[1:0];
      REG_WARNING_LEVEL:   shadow_cfg.warning_level   = data;
      REG_ALARM_LEVEL:     shadow_cfg.alarm_level     = data;
      REG_CHECK_WINDOW:    shadow_cfg.check_window    = data[15:0];
      REG_HIT_FRACTION:    shadow_cfg.hit_fraction    = data[CntW-1:0];
      REG_HOLD_SECONDS:    shadow_cfg.hold_seconds    = data[SecW-1:0];
      REG_DORMANT_SECONDS: shadow_cfg.dormant_seconds = data[SecW-1:0];
      default: ;
    endcase
  endtask

  task automatic load_config(input mode_e mode, input logic [DataW-1:0] warn_lvl,
                             input logic [DataW-1:0] alarm_lvl, input logic [15:0] window,
                             input logic [CntW-1:0] frac, input logic [SecW-1:0] hold,
                             input logic [SecW-1:0] dormancy);
    write_reg(REG_COMPARE_MODE, {30'b0, mode});
    write_reg(REG_WARNING_LEVEL, warn_lvl);
    write_reg(REG_ALARM_LEVEL, alarm_lvl);
    write_reg(REG_CHECK_WINDOW, {16'b0, window});
    write_reg(REG_HIT_FRACTION, {15'b0, frac});
    write_reg(REG_HOLD_SECONDS, {8'b0, hold});
    write_reg(REG_DORMANT_SECONDS, {8'b0, dormancy});
  endtask

  // random settings, mostly small windows and short timers so alarms cycle through,
  // with the register extremes mixed in now and then
  task automatic randomize_config();
    mode_e mode;
    logic [DataW-1:0] base;
    logic [DataW-1:0] gap;
    logic [DataW-1:0] warn_lvl;
    logic [DataW-1:0] alarm_lvl;
    logic [15:0] window;
    logic [CntW-1:0] frac;
    logic [SecW-1:0] hold;
    logic [SecW-1:0] dormancy;
    case ($urandom_range(5))
      0:       mode = $urandom_range(1) ? MODE_NONE : MODE_OFF;
      1, 2:    mode = MODE_LOW;
      default: mode = MODE_HIGH;
    endcase
    base = $urandom();
    gap  = $urandom_range(1, 32'h0010_0000);
    // warning level sits on the near side of the alarm level
    if (mode == MODE_LOW) begin
      alarm_lvl = base;
      warn_lvl  = base + gap;
    end else begin
      warn_lvl  = base;
      alarm_lvl = base + gap;
    end
    if ($urandom_range(7) == 0) alarm_lvl = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    if ($urandom_range(7) == 0) warn_lvl  = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    case ($urandom_range(15))
      0:       window = 16'd0;
      1:       window = 16'hFFFF;
      default: window = 16'($urandom_range(1, 12));
    endcase
    case ($urandom_range(9))
      0:       frac = '0;
      1:       frac = 17'd65536;
      default: frac = 17'($urandom_range(0, 65536));
    endcase
    case ($urandom_range(9))
      0:       hold = '0;
      1:       hold = 24'hFF_FFFF;
      default: hold = 24'($urandom_range(0, 15));
    endcase
    case ($urandom_range(9))
      0:       dormancy = '0;
      1:       dormancy = 24'hFF_FFFF;
      default: dormancy = 24'($urandom_range(0, 15));
    endcase
    load_config(mode, warn_lvl, alarm_lvl, window, frac, hold, dormancy);
    hot_pct = $urandom_range(0, 100);
  endtask

  // time mostly creeps forward, with occasional long or arbitrary jumps
  task automatic send_random_sample();
    logic [DataW-1:0] value;
    case ($urandom_range(49))
      0:       clock_seconds = $urandom();
      1:       clock_seconds += $urandom_range(0, 32'h0200_0000);
      default: clock_seconds += $urandom_range(0, 3);
    endcase
    if ($urandom_range(99) < hot_pct) begin
      if (shadow_cfg.compare_mode == MODE_LOW)
        value = shadow_cfg.alarm_level - $urandom_range(1, 64);
      else
        value = shadow_cfg.alarm_level + $urandom_range(1, 64);
    end else begin
      case ($urandom_range(5))
        0:       value = shadow_cfg.warning_level + $urandom_range(0, 4) - 2;
        1:       value = shadow_cfg.alarm_level + $urandom_range(0, 4) - 2;
        2:       value = $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
        default: value = $urandom();
      endcase
    end
    send_sample(value, clock_seconds);
  endtask

  // hand-picked requests: field extremes, all modes but off, strict fraction boundary,
  // hold and dormancy expiry, time wrap, ignored samples, window lowered mid-window
  task automatic test_directed_cases();
    // high mode, window of four, half rate, hold 5 s, no dormancy
    load_config(MODE_HIGH, 32'h0001_0000, 32'h0002_0000, 16'd3, 17'd32768, 24'd5, 24'd0);
    send_sample(32'h7FFF_FFFF, 32'd100);   // alarm level, restarts the window
    send_sample(32'h0001_8000, 32'd100);   // warning level
    send_sample(32'h8000_0000, 32'd101);   // normal
    send_sample(32'h0003_0000, 32'd101);   // two of four alarm hits: exactly half, no alarm
    repeat (4) send_sample(32'h0005_0000, 32'd102);  // four of four raises the alarm
    send_sample(32'h0000_0000, 32'd104);   // held, sample ignored
    send_sample(32'h0000_0000, 32'd107);   // hold ends, zero dormancy ends too
    wait_drained();

    // low mode, zero hold, time wrapping through zero
    load_config(MODE_LOW, 32'hFFFF_0000, 32'hFFFE_0000, 16'd3, 17'd16384, 24'd0, 24'd7);
    repeat (4) send_sample(32'hFFFD_0000, 32'hFFFF_FFFE);
    send_sample(32'h0000_0000, 32'd2);     // hold already over, dormancy starts
    send_sample(32'hFFFE_8000, 32'd9);     // dormancy runs out
    repeat (3) send_sample(32'hFFFE_8000, 32'd10);  // warning level hits
    send_sample(32'h0000_0000, 32'd11);    // window closes on a warning
    wait_drained();

    // no classification, register extremes
    load_config(MODE_NONE, 32'h8000_0000, 32'h7FFF_FFFF, 16'd1, 17'd0,
                24'hFF_FFFF, 24'hFF_FFFF);
    send_sample(32'h0000_0000, 32'd0);
    send_sample(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_drained();

    // widest window, then lowered below the running count
    load_config(MODE_HIGH, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 17'd65536,
                24'hFF_FFFF, 24'hFF_FFFF);
    send_sample(32'h0000_0000, 32'd20);
    send_sample(32'h1234_5678, 32'd21);
    wait_drained();
    write_reg(REG_CHECK_WINDOW, 32'd0);
    send_sample(32'h0000_0001, 32'd22);    // not classified, window evaluated at once
    wait_drained();
  endtask

  // random traffic in chunks, new settings between chunks while idle
  task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (5) begin
      wait_drained();
      randomize_config();
      repeat (80) send_random_sample();
    end
    wait_drained();
  endtask

  // receiver blocks for a long stretch while requests keep coming, so the
  // pipeline fills and input ready drops; then the sender waits for a full drain
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    randomize_config();
    rx_holdoff = 200;
    repeat (30) send_random_sample();
    wait_drained();
    repeat (30) send_random_sample();
    wait_drained();
  endtask

  // receiver: random stalls, or a forced hold-off counted down here
  always @(negedge clk_i) begin
    if (rx_holdoff != 0) begin
      rx_holdoff--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // every accepted result is compared with the oldest prediction
  always @(posedge clk_i) begin : check_results
    result_t want;
    result_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {sample_class_o, phase_o, alarm_raised_o, warning_raised_o,
             alarm_ended_o, dormancy_ended_o, seconds_left_o};
      n_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result with no request outstanding: class %0d phase %0d",
                   $realtime, got.sample_class, got.phase);
      end else begin
        want = pending_results.pop_front();
        if (got.sample_class !== want.sample_class || got.phase !== want.phase ||
            got.alarm_raised !== want.alarm_raised ||
            got.warning_raised !== want.warning_raised ||
            got.alarm_ended !== want.alarm_ended ||
            got.dormancy_ended !== want.dormancy_ended ||
            got.seconds_left !== want.seconds_left) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $write("%0t: expected class %0d phase %0d raised %b/%b ended %b/%b left %0d,",
                   $realtime, want.sample_class, want.phase, want.alarm_raised,
                   want.warning_raised, want.alarm_ended, want.dormancy_ended,
                   $signed(want.seconds_left));
            $display(" got class %0d phase %0d raised %b/%b ended %b/%b left %0d",
                     got.sample_class, got.phase, got.alarm_raised, got.warning_raised,
                     got.alarm_ended, got.dormancy_ended, $signed(got.seconds_left));
          end
        end
      end
    end
  end

  // hard stop well past the slowest legal run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    // register defaults and the empty checking state after reset
    shadow_cfg = '0;
    shadow_cfg.check_window    = 16'd10;
    shadow_cfg.hit_fraction    = 17'd32768;
    shadow_cfg.hold_seconds    = 24'd60;
    shadow_cfg.dormant_seconds = 24'd60;
    win_cnt       = '0;
    warn_hits     = '0;
    alarm_hits    = '0;
    first_pending = 1'b1;
    alarm_held    = 1'b0;
    dormant       = 1'b0;
    phase_t0      = '0;

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    test_directed_cases();
    test_random_traffic(0, 0);     // back to back in both directions
    test_random_traffic(81, 0);    // sparse requests
    test_random_traffic(0, 81);    // slow receiver
    test_random_traffic(12, 12);   // light gaps on both sides
    test_backpressure();

    wait_drained();
    repeat (5) @(posedge clk_i);
    $display("covered %0d requests (directed, four idling mixes, backpressure)", n_sent);
    $display("checked %0d: alarms %0d, warnings %0d, holds ended %0d, dormancy ended %0d",
             n_checked, n_alarms, n_warnings, n_holds_ended, n_dormant_end);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("mismatches %0d", mismatch_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
